// ===== rtl/core/ray_triangle_closest_hit_top_assert.svh =====
// Assertion macros for the closest-hit ray/triangle block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef RAY_TRIANGLE_CLOSEST_HIT_TOP_ASSERT_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_TOP_ASSERT_SVH
// same-cycle implication
`define RTCH_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rtch assertion failed");
// next-cycle implication
`define RTCH_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rtch assertion failed");
`endif

// ===== rtl/core/rtch_pkg.sv =====
// Shared types, constants and the datapath step program of the ray/triangle block.
// No dependencies.
package rtch_pkg;

  localparam int INDEX_BITS_DEF = 16;
  localparam int CFG_IDX_W      = 4;
  localparam int Q_DEPTH        = 2;
  localparam int N_STEPS        = 24;
  localparam int STEP_W         = 5;
  localparam int DIV_BITS       = 48;
  localparam int DIV_CNT_W      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_T    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_T    = 4'd7;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_ZERO    = 32'sd0;
  localparam q_t Q_ONE     = 32'sd65536;
  localparam q_t Q_MAX     = 32'sh7FFF_FFFF;
  localparam q_t BARY_LO   = -32'sd1;
  localparam q_t BARY_HI   = 32'sd65537;
  localparam logic signed [33:0] BARY_SUM_HI = 34'sd65537;

  typedef struct packed {
    q_t ox; q_t oy; q_t oz;
    q_t dx; q_t dy; q_t dz;
  } ray_t;

  typedef enum logic [4:0] {
    SRC_DIR0, SRC_DIR1, SRC_DIR2,
    SRC_E1_0, SRC_E1_1, SRC_E1_2,
    SRC_E2_0, SRC_E2_1, SRC_E2_2,
    SRC_D0,   SRC_D1,   SRC_D2,
    SRC_S1_0, SRC_S1_1, SRC_S1_2,
    SRC_S2_0, SRC_S2_1, SRC_S2_2
  } src_t;

  typedef enum logic [1:0] {OP_LOAD, OP_ADD, OP_SUB} op_t;

  typedef enum logic [3:0] {
    DST_NONE, DST_S1_0, DST_S1_1, DST_S1_2, DST_DIV, DST_NB1,
    DST_S2_0, DST_S2_1, DST_S2_2, DST_NB2, DST_NT
  } dst_t;

  typedef struct packed {
    src_t a;
    src_t b;
    op_t  op;
    dst_t dst;
  } step_t;

  // work handed from front to back
  typedef struct packed {
    q_t          divisor;
    q_t          nb1;
    q_t          nb2;
    q_t          nt;
    logic [15:0] tri_id;
    logic        last;
  } job_t;

  typedef struct packed {
    logic        hit_found;
    logic [15:0] hit_index;
    q_t          hit_t;
  } res_t;

  typedef enum logic [1:0] {F_IDLE, F_RUN, F_PUSH} fstate_t;
  typedef enum logic [1:0] {B_IDLE, B_DIV, B_EVAL, B_EMIT} bstate_t;
  typedef enum logic [1:0] {PH_B1, PH_B2, PH_T} phase_t;

  function automatic q_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic step_t mk(input src_t a, input src_t b, input op_t op, input dst_t dst);
    step_t s;
    s.a = a; s.b = b; s.op = op; s.dst = dst;
    return s;
  endfunction

  // s1 = dir x e2, divisor = s1.e1, nb1 = d.s1, s2 = d x e1, nb2 = dir.s2, nt = e2.s2
  function automatic step_t prog(input logic [STEP_W-1:0] s);
    case (s)
      5'd0:  return mk(SRC_DIR1, SRC_E2_2, OP_LOAD, DST_NONE);
      5'd1:  return mk(SRC_DIR2, SRC_E2_1, OP_SUB,  DST_S1_0);
      5'd2:  return mk(SRC_DIR2, SRC_E2_0, OP_LOAD, DST_NONE);
      5'd3:  return mk(SRC_DIR0, SRC_E2_2, OP_SUB,  DST_S1_1);
      5'd4:  return mk(SRC_DIR0, SRC_E2_1, OP_LOAD, DST_NONE);
      5'd5:  return mk(SRC_DIR1, SRC_E2_0, OP_SUB,  DST_S1_2);
      5'd6:  return mk(SRC_S1_0, SRC_E1_0, OP_LOAD, DST_NONE);
      5'd7:  return mk(SRC_S1_1, SRC_E1_1, OP_ADD,  DST_NONE);
      5'd8:  return mk(SRC_S1_2, SRC_E1_2, OP_ADD,  DST_DIV);
      5'd9:  return mk(SRC_D0,   SRC_S1_0, OP_LOAD, DST_NONE);
      5'd10: return mk(SRC_D1,   SRC_S1_1, OP_ADD,  DST_NONE);
      5'd11: return mk(SRC_D2,   SRC_S1_2, OP_ADD,  DST_NB1);
      5'd12: return mk(SRC_D1,   SRC_E1_2, OP_LOAD, DST_NONE);
      5'd13: return mk(SRC_D2,   SRC_E1_1, OP_SUB,  DST_S2_0);
      5'd14: return mk(SRC_D2,   SRC_E1_0, OP_LOAD, DST_NONE);
      5'd15: return mk(SRC_D0,   SRC_E1_2, OP_SUB,  DST_S2_1);
      5'd16: return mk(SRC_D0,   SRC_E1_1, OP_LOAD, DST_NONE);
      5'd17: return mk(SRC_D1,   SRC_E1_0, OP_SUB,  DST_S2_2);
      5'd18: return mk(SRC_DIR0, SRC_S2_0, OP_LOAD, DST_NONE);
      5'd19: return mk(SRC_DIR1, SRC_S2_1, OP_ADD,  DST_NONE);
      5'd20: return mk(SRC_DIR2, SRC_S2_2, OP_ADD,  DST_NB2);
      5'd21: return mk(SRC_E2_0, SRC_S2_0, OP_LOAD, DST_NONE);
      5'd22: return mk(SRC_E2_1, SRC_S2_1, OP_ADD,  DST_NONE);
      5'd23: return mk(SRC_E2_2, SRC_S2_2, OP_ADD,  DST_NT);
      default: return mk(SRC_DIR0, SRC_DIR0, OP_LOAD, DST_NONE);
    endcase
  endfunction

endpackage

// ===== rtl/core/rtch_if.sv =====
// Valid/ready channel interfaces: triangle items in, hit results out.
// No dependencies.
interface rtch_tri_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_x, a_y, a_z;
  logic signed [31:0] b_x, b_y, b_z;
  logic signed [31:0] c_x, c_y, c_z;
  logic [15:0]        tri_id;
  logic               last;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  tri_id, last, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  tri_id, last, output ready);
endinterface

interface rtch_hit_if;
  logic               valid;
  logic               ready;
  logic               hit_found;
  logic [15:0]        hit_index;
  logic signed [31:0] hit_t;
  modport source (output valid, hit_found, hit_index, hit_t, input ready);
  modport sink   (input valid, hit_found, hit_index, hit_t, output ready);
endinterface

// ===== rtl/core/ray_triangle_closest_hit_top.sv =====
// Closest-hit ray/triangle tester (Moller-Trumbore, saturating signed Q16.16).
// Load the ray through the cfg port (origin, direction, t window), then stream
// triangles; each with last=1 produces one result (found, index, t) and resets
// the query. The front end runs the 24 products of each triangle through a
// single 32x32 multiplier, plus load and hand-off. The back end runs a one-bit-
// per-cycle 48-bit divider; a triangle needs no quotient if its divisor is zero,
// one if b1 fails, two if b2 fails and three when t is computed; a result is
// posted from its own state. A two-deep queue between the ends lets the front
// work on the next triangle meanwhile.
// Configuration writes must only happen while no triangle is in flight.
module ray_triangle_closest_hit_top #(
  parameter int INDEX_BITS = rtch_pkg::INDEX_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rtch_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  rtch_tri_if.sink                       in_tri,
  rtch_hit_if.source                     out_hit
);

  // ray registers
  rtch_pkg::ray_t ray_r;
  rtch_pkg::q_t   min_t_r, max_t_r;

  rtch_pkg::job_t f_job, q_job;
  logic           f_valid, f_ready, q_valid, q_ready;
  rtch_pkg::res_t res;
  logic           res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r.ox <= rtch_pkg::Q_ZERO;
      ray_r.oy <= rtch_pkg::Q_ZERO;
      ray_r.oz <= rtch_pkg::Q_ZERO;
      ray_r.dx <= rtch_pkg::Q_ZERO;
      ray_r.dy <= rtch_pkg::Q_ZERO;
      ray_r.dz <= rtch_pkg::Q_ONE;
      min_t_r  <= rtch_pkg::Q_ZERO;
      max_t_r  <= rtch_pkg::Q_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        rtch_pkg::REG_ORIGIN_X: ray_r.ox <= cfg_wdata;
        rtch_pkg::REG_ORIGIN_Y: ray_r.oy <= cfg_wdata;
        rtch_pkg::REG_ORIGIN_Z: ray_r.oz <= cfg_wdata;
        rtch_pkg::REG_DIR_X:    ray_r.dx <= cfg_wdata;
        rtch_pkg::REG_DIR_Y:    ray_r.dy <= cfg_wdata;
        rtch_pkg::REG_DIR_Z:    ray_r.dz <= cfg_wdata;
        rtch_pkg::REG_MIN_T:    min_t_r  <= cfg_wdata;
        rtch_pkg::REG_MAX_T:    max_t_r  <= cfg_wdata;
        default: ;  // unused index: ignored
      endcase
    end
  end

  // front: edges and the six dot/cross results per triangle
  rtch_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .ray       (ray_r),
    .in_tri    (in_tri),
    .job       (f_job),
    .job_valid (f_valid),
    .job_ready (f_ready)
  );

  rtch_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (f_job),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_data   (q_job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready)
  );

  // back: quotients, tests and best-hit state
  rtch_back #(.INDEX_BITS(INDEX_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .min_t     (min_t_r),
    .max_t     (max_t_r),
    .job       (q_job),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (out_hit.ready)
  );

  assign out_hit.valid     = res_valid;
  assign out_hit.hit_found = res.hit_found;
  assign out_hit.hit_index = res.hit_index;
  assign out_hit.hit_t     = res.hit_t;

endmodule

// ===== rtl/core/rtch_front.sv =====
// Front end: takes a triangle, forms edges and runs the 24-product step program
// on one shared multiplier. Depends on rtch_pkg and rtch_if.
module rtch_front (
  input  logic             clk,
  input  logic             rst_n,
  input  rtch_pkg::ray_t   ray,
  rtch_tri_if.sink         in_tri,
  output rtch_pkg::job_t   job,
  output logic             job_valid,
  input  logic             job_ready
);

  rtch_pkg::fstate_t state_r, state_nxt;
  logic [rtch_pkg::STEP_W-1:0] sc_r, sc_nxt;
  logic pend_r, issue, accept;

  rtch_pkg::q_t e1_r [3];
  rtch_pkg::q_t e2_r [3];
  rtch_pkg::q_t d_r  [3];
  rtch_pkg::q_t s1_r [3];
  rtch_pkg::q_t s2_r [3];
  rtch_pkg::q_t div_r, nb1_r, nb2_r, nt_r;
  logic [15:0]  id_r;
  logic         last_r;

  rtch_pkg::step_t    st, pst_r;
  rtch_pkg::q_t       opa, opb, qm, wval;
  logic signed [63:0] prod_r;
  logic signed [33:0] acc_r, acc_nxt;

  function automatic rtch_pkg::q_t sel(input rtch_pkg::src_t s);
    case (s)
      rtch_pkg::SRC_DIR0: return ray.dx;
      rtch_pkg::SRC_DIR1: return ray.dy;
      rtch_pkg::SRC_DIR2: return ray.dz;
      rtch_pkg::SRC_E1_0: return e1_r[0];
      rtch_pkg::SRC_E1_1: return e1_r[1];
      rtch_pkg::SRC_E1_2: return e1_r[2];
      rtch_pkg::SRC_E2_0: return e2_r[0];
      rtch_pkg::SRC_E2_1: return e2_r[1];
      rtch_pkg::SRC_E2_2: return e2_r[2];
      rtch_pkg::SRC_D0:   return d_r[0];
      rtch_pkg::SRC_D1:   return d_r[1];
      rtch_pkg::SRC_D2:   return d_r[2];
      rtch_pkg::SRC_S1_0: return s1_r[0];
      rtch_pkg::SRC_S1_1: return s1_r[1];
      rtch_pkg::SRC_S1_2: return s1_r[2];
      rtch_pkg::SRC_S2_0: return s2_r[0];
      rtch_pkg::SRC_S2_1: return s2_r[1];
      rtch_pkg::SRC_S2_2: return s2_r[2];
      default:            return rtch_pkg::Q_ZERO;
    endcase
  endfunction

  assign in_tri.ready = (state_r == rtch_pkg::F_IDLE);
  assign accept       = in_tri.valid && in_tri.ready;
  assign issue        = (state_r == rtch_pkg::F_RUN) &&
                        (sc_r != rtch_pkg::STEP_W'(rtch_pkg::N_STEPS));

  always_comb begin
    state_nxt = state_r;
    sc_nxt    = sc_r;
    job_valid = 1'b0;
    case (state_r)
      rtch_pkg::F_IDLE: begin
        if (in_tri.valid) begin
          state_nxt = rtch_pkg::F_RUN;
          sc_nxt    = '0;
        end
      end
      rtch_pkg::F_RUN: begin
        if (sc_r == rtch_pkg::STEP_W'(rtch_pkg::N_STEPS)) state_nxt = rtch_pkg::F_PUSH;
        else sc_nxt = sc_r + 1'b1;
      end
      rtch_pkg::F_PUSH: begin
        job_valid = 1'b1;
        if (job_ready) state_nxt = rtch_pkg::F_IDLE;
      end
      default: state_nxt = rtch_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    st  = rtch_pkg::prog(sc_r);
    opa = sel(st.a);
    opb = sel(st.b);
    qm  = rtch_pkg::sat32(prod_r >>> 16);   // floor shift, then clamp
    case (pst_r.op)
      rtch_pkg::OP_LOAD: acc_nxt = 34'(qm);
      rtch_pkg::OP_ADD:  acc_nxt = acc_r + 34'(qm);
      rtch_pkg::OP_SUB:  acc_nxt = acc_r - 34'(qm);
      default:           acc_nxt = acc_r;
    endcase
    wval = rtch_pkg::sat32(64'(acc_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtch_pkg::F_IDLE;
      sc_r    <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sc_r    <= sc_nxt;
      pend_r  <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      e1_r[0] <= rtch_pkg::sat32(64'(in_tri.b_x) - 64'(in_tri.a_x));
      e1_r[1] <= rtch_pkg::sat32(64'(in_tri.b_y) - 64'(in_tri.a_y));
      e1_r[2] <= rtch_pkg::sat32(64'(in_tri.b_z) - 64'(in_tri.a_z));
      e2_r[0] <= rtch_pkg::sat32(64'(in_tri.c_x) - 64'(in_tri.a_x));
      e2_r[1] <= rtch_pkg::sat32(64'(in_tri.c_y) - 64'(in_tri.a_y));
      e2_r[2] <= rtch_pkg::sat32(64'(in_tri.c_z) - 64'(in_tri.a_z));
      d_r[0]  <= rtch_pkg::sat32(64'(ray.ox) - 64'(in_tri.a_x));
      d_r[1]  <= rtch_pkg::sat32(64'(ray.oy) - 64'(in_tri.a_y));
      d_r[2]  <= rtch_pkg::sat32(64'(ray.oz) - 64'(in_tri.a_z));
      id_r    <= in_tri.tri_id;
      last_r  <= in_tri.last;
    end
    if (issue) begin
      prod_r <= opa * opb;
      pst_r  <= st;
    end
    if (pend_r) begin
      acc_r <= acc_nxt;
      case (pst_r.dst)
        rtch_pkg::DST_S1_0: s1_r[0] <= wval;
        rtch_pkg::DST_S1_1: s1_r[1] <= wval;
        rtch_pkg::DST_S1_2: s1_r[2] <= wval;
        rtch_pkg::DST_DIV:  div_r   <= wval;
        rtch_pkg::DST_NB1:  nb1_r   <= wval;
        rtch_pkg::DST_S2_0: s2_r[0] <= wval;
        rtch_pkg::DST_S2_1: s2_r[1] <= wval;
        rtch_pkg::DST_S2_2: s2_r[2] <= wval;
        rtch_pkg::DST_NB2:  nb2_r   <= wval;
        rtch_pkg::DST_NT:   nt_r    <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    job.divisor = div_r;
    job.nb1     = nb1_r;
    job.nb2     = nb2_r;
    job.nt      = nt_r;
    job.tri_id  = id_r;
    job.last    = last_r;
  end

endmodule

// ===== rtl/core/rtch_queue.sv =====
// Small job queue between the front and back ends.
// Depends on rtch_pkg.
module rtch_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  rtch_pkg::job_t push_data,
  input  logic           push_valid,
  output logic           push_ready,
  output rtch_pkg::job_t pop_data,
  output logic           pop_valid,
  input  logic           pop_ready
);

  localparam int PW = (rtch_pkg::Q_DEPTH > 1) ? $clog2(rtch_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(rtch_pkg::Q_DEPTH + 1);

  rtch_pkg::job_t mem_r [rtch_pkg::Q_DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  cnt_r;
  logic           push, pop;

  assign push_ready = (cnt_r != CW'(rtch_pkg::Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [PW-1:0] wrap(input logic [PW-1:0] p);
    return (p == PW'(rtch_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wrap(wp_r);
      if (pop)  rp_r <= wrap(rp_r);
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

// ===== rtl/core/rtch_back.sv =====
// Back end: bit-serial divider for b1, b2 and t, barycentric and window tests,
// best-hit tracking and the result register. Depends on rtch_pkg.
module rtch_back #(
  parameter int INDEX_BITS = rtch_pkg::INDEX_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  rtch_pkg::q_t   min_t,
  input  rtch_pkg::q_t   max_t,
  input  rtch_pkg::job_t job,
  input  logic           job_valid,
  output logic           job_ready,
  output rtch_pkg::res_t res,
  output logic           res_valid,
  input  logic           res_ready
);

  localparam int DB = rtch_pkg::DIV_BITS;

  rtch_pkg::bstate_t state_r, state_nxt;
  rtch_pkg::phase_t  phase_r, phase_nxt;
  rtch_pkg::job_t    job_r;
  logic [rtch_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [DB-1:0]     n_r;
  logic [31:0]       rem_r, dv_r;
  logic              neg_r;
  rtch_pkg::q_t      b1_r, best_t_r;
  logic [INDEX_BITS-1:0] best_idx_r;
  logic              any_r;
  rtch_pkg::res_t    out_r;
  logic              out_v_r;

  logic              start, take_hit, emit;
  rtch_pkg::q_t      start_num, start_den, qv, cap;
  logic [32:0]       rem_sh;
  logic              ge;
  logic signed [DB:0] qs;

  assign job_ready = (state_r == rtch_pkg::B_IDLE);
  assign res       = out_r;
  assign res_valid = out_v_r;

  assign rem_sh = {rem_r, n_r[DB-1]};
  assign ge     = (rem_sh >= {1'b0, dv_r});
  assign qs     = neg_r ? -$signed({1'b0, n_r}) : $signed({1'b0, n_r});
  assign qv     = rtch_pkg::sat32(64'(qs));
  assign cap    = any_r ? best_t_r : max_t;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    start     = 1'b0;
    start_num = job_r.nb1;
    take_hit  = 1'b0;
    emit      = 1'b0;
    case (state_r)
      rtch_pkg::B_IDLE: begin
        if (job_valid) begin
          if (job.divisor == rtch_pkg::Q_ZERO) begin
            state_nxt = job.last ? rtch_pkg::B_EMIT : rtch_pkg::B_IDLE;
          end else begin
            start     = 1'b1;
            start_num = job.nb1;
            phase_nxt = rtch_pkg::PH_B1;
            state_nxt = rtch_pkg::B_DIV;
          end
        end
      end
      rtch_pkg::B_DIV: begin
        if (cnt_r == rtch_pkg::DIV_CNT_W'(DB - 1)) state_nxt = rtch_pkg::B_EVAL;
      end
      rtch_pkg::B_EVAL: begin
        state_nxt = job_r.last ? rtch_pkg::B_EMIT : rtch_pkg::B_IDLE;
        case (phase_r)
          rtch_pkg::PH_B1: begin
            if (!(qv < rtch_pkg::BARY_LO || qv > rtch_pkg::BARY_HI)) begin
              start     = 1'b1;
              start_num = job_r.nb2;
              phase_nxt = rtch_pkg::PH_B2;
              state_nxt = rtch_pkg::B_DIV;
            end
          end
          rtch_pkg::PH_B2: begin
            if (!(qv < rtch_pkg::BARY_LO ||
                  (34'(b1_r) + 34'(qv)) > rtch_pkg::BARY_SUM_HI)) begin
              start     = 1'b1;
              start_num = job_r.nt;
              phase_nxt = rtch_pkg::PH_T;
              state_nxt = rtch_pkg::B_DIV;
            end
          end
          rtch_pkg::PH_T: begin
            take_hit = (qv >= min_t) && (qv <= cap);
          end
          default: ;
        endcase
      end
      rtch_pkg::B_EMIT: begin
        if (!out_v_r || res_ready) begin
          emit      = 1'b1;
          state_nxt = rtch_pkg::B_IDLE;
        end
      end
      default: state_nxt = rtch_pkg::B_IDLE;
    endcase
    start_den = (state_r == rtch_pkg::B_IDLE) ? job.divisor : job_r.divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rtch_pkg::B_IDLE;
      phase_r    <= rtch_pkg::PH_B1;
      any_r      <= 1'b0;
      best_idx_r <= '0;
      out_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (emit) begin
        any_r      <= 1'b0;
        best_idx_r <= '0;
      end else if (take_hit) begin
        any_r      <= 1'b1;
        best_idx_r <= INDEX_BITS'(job_r.tri_id);
      end
      if (emit) out_v_r <= 1'b1;
      else if (res_ready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) job_r <= job;
    if (start) begin
      n_r   <= {(start_num[31] ? (~start_num + 1'b1) : start_num), 16'b0};
      dv_r  <= start_den[31] ? (~start_den + 1'b1) : start_den;
      neg_r <= start_num[31] ^ start_den[31];
      rem_r <= '0;
      cnt_r <= '0;
    end else if (state_r == rtch_pkg::B_DIV) begin
      rem_r <= ge ? 32'(rem_sh - {1'b0, dv_r}) : rem_sh[31:0];
      n_r   <= {n_r[DB-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
    end
    if (state_r == rtch_pkg::B_EVAL && phase_r == rtch_pkg::PH_B1) b1_r <= qv;
    if (take_hit) best_t_r <= qv;
    if (emit) begin
      out_r.hit_found <= any_r;
      out_r.hit_index <= any_r ? 16'(best_idx_r) : 16'd0;
      out_r.hit_t     <= any_r ? best_t_r : max_t;
    end
  end

endmodule

// ===== rtl/core/rtch_checker.sv =====
// Port-level checks for the closest-hit block, bound to the top level.
// Depends on ray_triangle_closest_hit_top_assert.svh.
`include "ray_triangle_closest_hit_top_assert.svh"

module rtch_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [15:0] out_index
);

  // a posted result waits until taken
  `RTCH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  // a miss reports index zero
  `RTCH_ASSERT_NOW(a_miss_index, out_valid && !out_found, out_index == 16'd0)
  // a waiting result keeps its payload
  `RTCH_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_found) && $stable(out_index))
  // the front end is busy right after it takes an item
  `RTCH_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready)

endmodule

bind ray_triangle_closest_hit_top rtch_checker u_rtch_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_tri.valid),
  .in_ready  (in_tri.ready),
  .out_valid (out_hit.valid),
  .out_ready (out_hit.ready),
  .out_found (out_hit.hit_found),
  .out_index (out_hit.hit_index)
);

// ===== test/rtch_hit_checker.sv =====
// Checker for the closest-hit ray/triangle block: watches the cfg port and both
// channels, predicts each hit result and compares. Depends on rtch_pkg, rtch_if.
`timescale 1ns / 100ps

module rtch_hit_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rtch_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_wdata,
  rtch_tri_if                            tri_mon,
  rtch_hit_if                            hit_mon,
  output int                             fail_count,
  output int                             pending,
  output int                             result_count,
  output int                             found_count
);

  localparam longint QS = 65536;
  localparam int     N_REGS = 8;

  longint   ray_reg [N_REGS];
  longint   best_t;
  logic [15:0] best_id;
  logic     any_hit;
  rtch_pkg::res_t hit_expect_q [$];
  int       n_fail, n_res, n_found;

  function automatic longint sat(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qsub(input longint a, input longint b);
    return sat(a - b);
  endfunction

  // floor shift of the exact product
  function automatic longint qmul(input longint a, input longint b);
    return sat((a * b) >>> 16);
  endfunction

  function automatic longint qdiv(input longint num, input longint den);
    return sat((num * QS) / den);
  endfunction

  function automatic longint qdot(input longint ax, input longint ay, input longint az,
                                  input longint bx, input longint by, input longint bz);
    return sat(qmul(ax, bx) + qmul(ay, by) + qmul(az, bz));
  endfunction

  function automatic void clear_query();
    best_t  = ray_reg[rtch_pkg::REG_MAX_T];
    best_id = '0;
    any_hit = 1'b0;
  endfunction

  // Moller-Trumbore test of one triangle, folding an accepted hit into the best
  function automatic void fold_triangle();
    longint ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z, dx, dy, dz;
    longint rx, ry, rz, s1x, s1y, s1z, s2x, s2y, s2z;
    longint dv, b1, b2, t, cap;
    ax = tri_mon.a_x; ay = tri_mon.a_y; az = tri_mon.a_z;
    e1x = qsub(tri_mon.b_x, ax); e1y = qsub(tri_mon.b_y, ay); e1z = qsub(tri_mon.b_z, az);
    e2x = qsub(tri_mon.c_x, ax); e2y = qsub(tri_mon.c_y, ay); e2z = qsub(tri_mon.c_z, az);
    dx = qsub(ray_reg[rtch_pkg::REG_ORIGIN_X], ax);
    dy = qsub(ray_reg[rtch_pkg::REG_ORIGIN_Y], ay);
    dz = qsub(ray_reg[rtch_pkg::REG_ORIGIN_Z], az);
    rx = ray_reg[rtch_pkg::REG_DIR_X];
    ry = ray_reg[rtch_pkg::REG_DIR_Y];
    rz = ray_reg[rtch_pkg::REG_DIR_Z];
    s1x = qsub(qmul(ry, e2z), qmul(rz, e2y));
    s1y = qsub(qmul(rz, e2x), qmul(rx, e2z));
    s1z = qsub(qmul(rx, e2y), qmul(ry, e2x));
    dv = qdot(s1x, s1y, s1z, e1x, e1y, e1z);
    if (dv == 0) return;
    b1 = qdiv(qdot(dx, dy, dz, s1x, s1y, s1z), dv);
    if (b1 < -1 || b1 > QS + 1) return;
    s2x = qsub(qmul(dy, e1z), qmul(dz, e1y));
    s2y = qsub(qmul(dz, e1x), qmul(dx, e1z));
    s2z = qsub(qmul(dx, e1y), qmul(dy, e1x));
    b2 = qdiv(qdot(rx, ry, rz, s2x, s2y, s2z), dv);
    if (b2 < -1 || b1 + b2 > QS + 1) return;
    t = qdiv(qdot(e2x, e2y, e2z, s2x, s2y, s2z), dv);
    cap = any_hit ? best_t : ray_reg[rtch_pkg::REG_MAX_T];
    if (t >= ray_reg[rtch_pkg::REG_MIN_T] && t <= cap) begin
      best_t  = t;
      best_id = tri_mon.tri_id;
      any_hit = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    rtch_pkg::res_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < N_REGS; i++) ray_reg[i] = 0;
      ray_reg[rtch_pkg::REG_DIR_Z] = QS;
      ray_reg[rtch_pkg::REG_MAX_T] = 64'sd2147483647;
      clear_query();
      hit_expect_q.delete();
      n_fail = 0; n_res = 0; n_found = 0;
    end else begin
      if (cfg_we && cfg_index < N_REGS)
        ray_reg[cfg_index] = longint'($signed(cfg_wdata));
      if (hit_mon.valid && hit_mon.ready) begin
        got.hit_found = hit_mon.hit_found;
        got.hit_index = hit_mon.hit_index;
        got.hit_t     = hit_mon.hit_t;
        n_res++;
        if (got.hit_found) n_found++;
        if (hit_expect_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("[%0t] unexpected result: found=%0b index=%0d t=%0d",
                     $realtime, got.hit_found, got.hit_index, got.hit_t);
        end else begin
          want = hit_expect_q.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= 10)
              $display("[%0t] mismatch: expected found=%0b index=%0d t=%0d, got found=%0b index=%0d t=%0d",
                       $realtime, want.hit_found, want.hit_index, want.hit_t,
                       got.hit_found, got.hit_index, got.hit_t);
          end
        end
      end
      if (tri_mon.valid && tri_mon.ready) begin
        fold_triangle();
        if (tri_mon.last) begin
          want.hit_found = any_hit;
          want.hit_index = any_hit ? best_id : 16'd0;
          want.hit_t     = any_hit ? rtch_pkg::q_t'(best_t)
                                   : rtch_pkg::q_t'(ray_reg[rtch_pkg::REG_MAX_T]);
          hit_expect_q = {hit_expect_q, want};
          clear_query();
        end
      end
    end
    fail_count   <= n_fail;
    pending      <= hit_expect_q.size();
    result_count <= n_res;
    found_count  <= n_found;
  end

endmodule

// ===== test/ray_triangle_closest_hit_top_tb.sv =====
// Testbench top for ray_triangle_closest_hit_top: clock, reset, ray settings,
// triangle stimulus and verdict. Depends on rtch_pkg, rtch_if, rtch_hit_checker.
`timescale 1ns / 100ps

module ray_triangle_closest_hit_top_tb;

  localparam int  Q          = 65536;
  localparam rtch_pkg::q_t  S_MAX      = 32'sh7FFF_FFFF;
  localparam rtch_pkg::q_t  S_MIN      = 32'sh8000_0000;
  localparam logic [rtch_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd8;
  localparam int  N_PHASES   = 10;
  localparam int  PHASE_ITEMS = 165;
  localparam int  DRAIN_CYCLES = 400;   // two queued triangles with full divides, plus margin

  typedef struct {
    rtch_pkg::q_t ax, ay, az, bx, by, bz, cx, cy, cz;
    logic [15:0] id;
    logic        last;
  } tri_item_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [rtch_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_wdata;

  rtch_tri_if in_tri ();
  rtch_hit_if out_hit ();

  int fail_count, pending, result_count, found_count;
  int burst_left;
  int sent;
  int stall_mode, stall_left;
  rtch_pkg::q_t ray_cfg [8];          // value per register for the next setting
  rtch_pkg::q_t ray_o [3], ray_d [3]; // current ray, for aiming triangles

  ray_triangle_closest_hit_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tri    (in_tri),
    .out_hit   (out_hit)
  );

  rtch_hit_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .tri_mon      (in_tri),
    .hit_mon      (out_hit),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .found_count  (found_count)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Generous hard stop in case the run hangs.
  initial begin
    #40000000;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver stalls: modes change every so often - always ready, coin flip,
  // or mostly stalled.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        out_hit.ready <= 1'b1;
      end
      1: begin
        out_hit.ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_hit.ready <= ($urandom_range(0, 5) == 0);
      end
    endcase
  end

  // Drive one triangle item; bursts of random length with random gaps between.
  task automatic send_tri(input tri_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
      if (gap > 0) begin
        in_tri.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tri.valid  <= 1'b1;
    in_tri.a_x <= it.ax; in_tri.a_y <= it.ay; in_tri.a_z <= it.az;
    in_tri.b_x <= it.bx; in_tri.b_y <= it.by; in_tri.b_z <= it.bz;
    in_tri.c_x <= it.cx; in_tri.c_y <= it.cy; in_tri.c_z <= it.cz;
    in_tri.tri_id <= it.id;
    in_tri.last   <= it.last;
    do @(posedge clk); while (!in_tri.ready);
    burst_left--;
    sent++;
  endtask

  // Sender holds off until every expected result is back and the block drained.
  task automatic wait_idle();
    in_tri.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all ray registers back to back, optionally with a stray index too.
  task automatic load_ray(input bit stray);
    wait_idle();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[rtch_pkg::CFG_IDX_W-1:0];
      cfg_wdata <= ray_cfg[i];
      @(posedge clk);
    end
    if (stray) begin
      cfg_index <= REG_UNUSED;
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 3; k++) begin
      ray_o[k] = ray_cfg[rtch_pkg::REG_ORIGIN_X + k];
      ray_d[k] = ray_cfg[rtch_pkg::REG_DIR_X + k];
    end
  endtask

  // triangle from whole-unit coordinates
  function automatic tri_item_t tri_u(input int ax, ay, az, bx, by, bz, cx, cy, cz,
                                      input int id, input bit last);
    tri_item_t t;
    t.ax = ax * Q; t.ay = ay * Q; t.az = az * Q;
    t.bx = bx * Q; t.by = by * Q; t.bz = bz * Q;
    t.cx = cx * Q; t.cy = cy * Q; t.cz = cz * Q;
    t.id = 16'(id); t.last = last;
    return t;
  endfunction

  function automatic rtch_pkg::q_t rnd_span(input int span_units);
    return $signed($urandom_range(0, 2 * span_units * Q)) - span_units * Q;
  endfunction

  // Triangle placed around a point on the current ray, so most of them hit.
  function automatic tri_item_t aimed_tri();
    tri_item_t t;
    longint tq;
    rtch_pkg::q_t p [3];
    tq = $urandom_range(0, 12 * Q);
    for (int k = 0; k < 3; k++)
      p[k] = rtch_pkg::q_t'(longint'(ray_o[k]) + ((longint'(ray_d[k]) * tq) >>> 16));
    t.ax = p[0] - $urandom_range(Q / 4, 3 * Q);
    t.ay = p[1] - $urandom_range(Q / 4, 3 * Q);
    t.az = p[2] + rnd_span(1);
    t.bx = p[0] + $urandom_range(Q / 4, 3 * Q);
    t.by = p[1] - $urandom_range(Q / 4, 3 * Q);
    t.bz = p[2] + rnd_span(1);
    t.cx = p[0] + rnd_span(1);
    t.cy = p[1] + $urandom_range(Q / 4, 3 * Q);
    t.cz = p[2] + rnd_span(1);
    t.id = 16'($urandom);
    t.last = 1'b0;
    return t;
  endfunction

  function automatic tri_item_t noise_tri(input bit full_range);
    tri_item_t t;
    if (full_range) begin
      t.ax = $urandom; t.ay = $urandom; t.az = $urandom;
      t.bx = $urandom; t.by = $urandom; t.bz = $urandom;
      t.cx = $urandom; t.cy = $urandom; t.cz = $urandom;
    end else begin
      t.ax = rnd_span(16); t.ay = rnd_span(16); t.az = rnd_span(16);
      t.bx = rnd_span(16); t.by = rnd_span(16); t.bz = rnd_span(16);
      t.cx = rnd_span(16); t.cy = rnd_span(16); t.cz = rnd_span(16);
    end
    t.id = 16'($urandom);
    t.last = 1'b0;
    return t;
  endfunction

  // Ray setting for a phase: extremes first, then random small rays.
  task automatic pick_ray(input int ph);
    case (ph)
      1: begin  // saturating extremes everywhere, widest window
        ray_cfg = '{S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MIN, S_MAX};
      end
      2: begin  // empty window: min_t above max_t
        ray_cfg = '{0, 0, 0, 0, 0, Q, 8 * Q, 2 * Q};
      end
      3: begin  // negative window, opposite extremes
        ray_cfg = '{S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, -Q};
      end
      default: begin
        for (int k = 0; k < 3; k++) begin
          ray_cfg[rtch_pkg::REG_ORIGIN_X + k] = rnd_span(4);
          ray_cfg[rtch_pkg::REG_DIR_X + k]    = rnd_span(2);
        end
        ray_cfg[rtch_pkg::REG_MIN_T] = ($urandom_range(0, 3) == 0) ? rnd_span(2) : 0;
        ray_cfg[rtch_pkg::REG_MAX_T] = ($urandom_range(0, 2) == 0) ? S_MAX
                                                        : $urandom_range(Q, 16 * Q);
      end
    endcase
  endtask

  initial begin
    tri_item_t it, prev;
    int qlen;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_tri.valid = 1'b0;
    in_tri.a_x = '0; in_tri.a_y = '0; in_tri.a_z = '0;
    in_tri.b_x = '0; in_tri.b_y = '0; in_tri.b_z = '0;
    in_tri.c_x = '0; in_tri.c_y = '0; in_tri.c_z = '0;
    in_tri.tri_id = '0; in_tri.last = 1'b0;
    out_hit.ready = 1'b0;
    stall_mode = 0; stall_left = 0;
    burst_left = 0; sent = 0;
    ray_o = '{0, 0, 0};
    ray_d = '{0, 0, Q};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part on the reset ray: origin 0, looking down +z, window [0, max].
    send_tri(tri_u(-1, -1, 5,  3, -1, 5, -1, 3, 5, 1, 0));  // plain hit at t = 5
    send_tri(tri_u(-1, -1, 5,  3, -1, 5, -1, 3, 5, 2, 0));  // equal t: later one wins
    send_tri(tri_u(0, 0, 0,  0, 0, 0,  0, 0, 0, 3, 0));     // degenerate, zero divisor
    send_tri(tri_u(10, -1, 5, 14, -1, 5, 10, 3, 5, 4, 0));  // first barycentric out
    send_tri(tri_u(-1, 10, 5, 3, 10, 5, -1, 14, 5, 5, 0));  // second barycentric out
    send_tri(tri_u(2, 2, 3,  2, -1, 3, -1, 2, 3, 6, 0));    // barycentric sum past one
    send_tri(tri_u(-1, -1, -5, 3, -1, -5, -1, 3, -5, 7, 0)); // behind the origin
    send_tri(tri_u(-1, -1, 2, 3, -1, 2, -1, 3, 2, 8, 1));   // closer hit ends query
    send_tri(tri_u(0, 0, 0,  0, 0, 0,  0, 0, 0, 16'hFFFF, 1)); // query with no hit
    it = '{S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, 16'hFFFF, 1'b0};
    send_tri(it);
    it = '{S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, 16'h0000, 1'b0};
    send_tri(it);
    it = '{S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, 16'h5555, 1'b1};
    send_tri(it);
    send_tri(tri_u(-1, -1, 9, 3, -1, 9, -1, 3, 9, 16'hFFFF, 1)); // one-item query
    send_tri(tri_u(0, 0, 3,  1, 0, 3,  0, 1, 3, 16'h0000, 1));   // hit right on a vertex
    send_tri(tri_u(-2, -2, 4, 2, -2, 4, -2, 2, 4, 16'hAAAA, 1)); // hit on an edge

    // Random part: phases of ray settings, each a run of short queries.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        pick_ray(ph);
        load_ray(ph == 1);
      end
      for (int n = 0; n < PHASE_ITEMS; n += qlen) begin
        qlen = $urandom_range(1, 8);
        for (int j = 0; j < qlen; j++) begin
          case ($urandom_range(0, 19))
            0, 1, 2: it = noise_tri(1'b0);
            3, 4:    it = noise_tri(1'b1);
            5:       it = (j > 0) ? prev : aimed_tri();   // repeat for equal t
            default: it = aimed_tri();
          endcase
          if (j > 0 && it.id == prev.id) it.id = 16'($urandom);
          it.last = (j == qlen - 1);
          if ($urandom_range(0, 39) == 0) it.last = ~it.last;  // broken query ends
          prev = it;
          send_tri(it);
        end
      end
      // close any query a flipped end left open
      it = noise_tri(1'b0);
      it.last = 1'b1;
      send_tri(it);
    end

    wait_idle();
    $display("Sent %0d triangles over %0d ray settings; %0d results checked, %0d with a hit.",
             sent, N_PHASES, result_count, found_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures, %0d results still owed", fail_count, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
